@@ hdl/lmcb_pkg.sv @@
// -----------------------------------------------------------------------------
// lmcb_pkg
// Shared types, constants and helper functions for the LED matrix canvas
// blitter and refresh sequencer.
// -----------------------------------------------------------------------------
package lmcb_pkg;

   // Geometry of the canvas and the device chain.
   localparam int MAX_DEVICES     = 8;
   localparam int ROWS_PER_DEVICE = 8;
   localparam int CANVAS_DEPTH    = MAX_DEVICES * ROWS_PER_DEVICE;
   localparam int CANVAS_ADDR_W   = $clog2(CANVAS_DEPTH);
   localparam int DEVICE_W        = $clog2(MAX_DEVICES);
   localparam int ROW_W           = $clog2(ROWS_PER_DEVICE);
   localparam int COUNT_W         = 4;

   // Device register addresses.
   localparam logic [3:0] REG_INTENSITY = 4'd10;
   localparam logic [3:0] REG_SHUTDOWN  = 4'd12;

   // Reset value of the device count register.
   localparam logic [COUNT_W-1:0] DEVICE_COUNT_RESET = COUNT_W'(MAX_DEVICES);

   // Input command codes.
   typedef enum logic [2:0] {
      CMD_BLIT_ROW      = 3'd0,
      CMD_REFRESH       = 3'd1,
      CMD_CLEAR         = 3'd2,
      CMD_SET_INTENSITY = 3'd3,
      CMD_SET_SHUTDOWN  = 3'd4
   } cmd_type;

   // Source of the canvas read address.
   typedef enum logic [1:0] {
      RD_LEFT  = 2'd0,
      RD_RIGHT = 2'd1,
      RD_SEQ   = 2'd2
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_item;
      logic       seq_start;
      logic       clear_canvas;
      logic       clear_dirty;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cap_left;
      logic       wr_left;
      logic       wr_right;
      logic       load_seq_rsp;
      logic       load_bcast_rsp;
      logic       next_row;
      logic       next_dev;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type command;
      logic    blit_ok;
      logic    intensity_ok;
      logic    scan_done;
      logic    scan_hit;
      logic    row_last;
      logic    bcast_last;
   } dp_status_type;

   // Reverses the bit order of a byte.
   function automatic logic [7:0] rev8(input logic [7:0] x);
      logic [7:0] v;
      v = ((x >> 1) & 8'h55) | ((x << 1) & 8'haa);
      v = ((v >> 2) & 8'h33) | ((v << 2) & 8'hcc);
      v = ((v >> 4) & 8'h0f) | ((v << 4) & 8'hf0);
      return v;
   endfunction

endpackage

@@ hdl/lmcb_ram.sv @@
// -----------------------------------------------------------------------------
// lmcb_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module lmcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is requested.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lmcb_ctrl.sv @@
// -----------------------------------------------------------------------------
// lmcb_ctrl
// Controller state machine: decodes each transaction and steps the datapath
// through the blit read-modify-write, the refresh scan and the broadcasts.
// -----------------------------------------------------------------------------
module lmcb_ctrl
   import lmcb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_BLIT_RD0,
      ST_BLIT_RD1,
      ST_BLIT_WR0,
      ST_BLIT_WR1,
      ST_SCAN,
      ST_SEQ_RD,
      ST_SEQ_LOAD,
      ST_SEQ_WAIT,
      ST_BCAST_LOAD,
      ST_BCAST_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_SEQ;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.seq_start = 1'b1;
            unique case (status.command)
               CMD_BLIT_ROW: begin
                  state_in = status.blit_ok ? ST_BLIT_RD0 : ST_IDLE;
               end
               CMD_REFRESH: begin
                  state_in = ST_SCAN;
               end
               CMD_CLEAR: begin
                  cmd.clear_canvas = 1'b1;
                  state_in         = ST_SCAN;
               end
               CMD_SET_INTENSITY: begin
                  state_in = status.intensity_ok ? ST_BCAST_LOAD : ST_IDLE;
               end
               CMD_SET_SHUTDOWN: begin
                  state_in = ST_BCAST_LOAD;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_BLIT_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LEFT;
            state_in   = ST_BLIT_RD1;
         end
         ST_BLIT_RD1: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_RIGHT;
            cmd.cap_left = 1'b1;
            state_in     = ST_BLIT_WR0;
         end
         ST_BLIT_WR0: begin
            cmd.wr_left = 1'b1;
            state_in    = ST_BLIT_WR1;
         end
         ST_BLIT_WR1: begin
            cmd.wr_right = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            // Walk the devices in use, stopping at each dirty one.
            if (status.scan_done) begin
               cmd.clear_dirty = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.scan_hit) begin
               state_in = ST_SEQ_RD;
            end else begin
               cmd.next_dev = 1'b1;
            end
         end
         ST_SEQ_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SEQ;
            state_in   = ST_SEQ_LOAD;
         end
         ST_SEQ_LOAD: begin
            cmd.load_seq_rsp = 1'b1;
            state_in         = ST_SEQ_WAIT;
         end
         ST_SEQ_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.row_last) begin
                  cmd.next_dev = 1'b1;
                  state_in     = ST_SCAN;
               end else begin
                  cmd.next_row = 1'b1;
                  state_in     = ST_SEQ_RD;
               end
            end
         end
         ST_BCAST_LOAD: begin
            cmd.load_bcast_rsp = 1'b1;
            state_in           = ST_BCAST_WAIT;
         end
         ST_BCAST_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.bcast_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_dev = 1'b1;
                  state_in     = ST_BCAST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/lmcb_datapath.sv @@
// -----------------------------------------------------------------------------
// lmcb_datapath
// Canvas memory with per-entry valid bits, dirty mask, device count register,
// blit merge logic, scan counters and the result register.
// -----------------------------------------------------------------------------
module lmcb_datapath
   import lmcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_command,
   input  logic signed [6:0]   req_display_column,
   input  logic [3:0]          req_sprite_width,
   input  logic [2:0]          req_row,
   input  logic [7:0]          req_sprite_byte,
   input  logic [7:0]          req_value,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   output logic [DEVICE_W-1:0] rsp_device,
   output logic [3:0]          rsp_register_address,
   output logic [7:0]          rsp_write_data,
   output logic                rsp_last
);

   // Captured transaction fields.
   cmd_type            cmd_ff;
   logic signed [6:0]  col_ff;
   logic [3:0]         width_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [7:0]         sprite_ff;
   logic [7:0]         value_ff;

   // Control state.
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [MAX_DEVICES-1:0]  dirty_ff, dirty_in;
   logic [CANVAS_DEPTH-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]      seq_dev_ff, seq_dev_in;
   logic [ROW_W-1:0]        seq_row_ff, seq_row_in;

   // Datapath registers.
   logic [7:0]          left_ff;
   logic [7:0]          right_ff;
   logic                rd_valid_ff;
   logic [DEVICE_W-1:0] rsp_device_ff;
   logic [3:0]          rsp_reg_ff;
   logic [7:0]          rsp_data_ff;
   logic                rsp_last_ff;

   // Memory port signals.
   logic                     ram_we;
   logic [CANVAS_ADDR_W-1:0] ram_waddr;
   logic [7:0]               ram_wdata;
   logic [CANVAS_ADDR_W-1:0] ram_raddr;
   logic [7:0]               ram_rdata;
   logic [7:0]               rdata_eff;

   // Blit geometry and merge.
   logic [2:0]               dc8;
   logic [CANVAS_ADDR_W-1:0] addr0;
   logic [CANVAS_ADDR_W-1:0] addr8;
   logic                     left_ok;
   logic                     right_ok;
   logic [7:0]               reach;
   logic                     width_ok;
   logic                     on_screen;
   logic [DEVICE_W-1:0]      blit_dev;
   logic [1:0]               pair;
   logic [MAX_DEVICES-1:0]   dirty_add;
   logic [7:0]               sm;
   logic [7:0]               s;
   logic [15:0]              sr16;
   logic [15:0]              s16;
   logic [15:0]              merged;

   // Scan helpers.
   logic [MAX_DEVICES-1:0]   used_mask;
   logic [MAX_DEVICES-1:0]   above_mask;
   logic [MAX_DEVICES-1:0]   remaining;
   logic [CANVAS_DEPTH-1:0]  clear_bits;
   logic [CANVAS_ADDR_W-1:0] seq_addr;

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff    <= cmd_type'(req_command);
         col_ff    <= req_display_column;
         width_ff  <= req_sprite_width;
         row_ff    <= req_row;
         sprite_ff <= req_sprite_byte;
         value_ff  <= req_value;
      end
   end

   // Blit geometry: the left byte sits at base + row, the right one 8 rows on.
   assign dc8       = col_ff[2:0];
   assign addr0     = {col_ff[5:3], row_ff};
   assign addr8     = {col_ff[5:3] + 3'd1, row_ff};
   assign left_ok   = !col_ff[6];
   assign right_ok  = !(!col_ff[6] && (col_ff[5:3] == 3'b111));
   assign reach     = {col_ff[6], col_ff} + {4'b0000, width_ff};
   assign width_ok  = (width_ff != 4'd0) && (width_ff <= 4'd8);
   assign on_screen = !reach[7] && (reach != 8'd0)
                      && !(!col_ff[6] && ({1'b0, col_ff[5:0]} >= {count_ff, 3'b000}));
   assign blit_dev  = col_ff[6] ? '0 : col_ff[5:3];
   assign pair      = (({1'b0, dc8} + width_ff) <= 4'd8) ? 2'b01 : 2'b11;
   assign dirty_add = MAX_DEVICES'({{(MAX_DEVICES-2){1'b0}}, pair} << blit_dev);

   // Merge the reversed sprite bits into the two canvas bytes.
   assign sm     = 8'((9'h001 << width_ff) - 9'h001);
   assign s      = sm & (rev8(sprite_ff) >> (4'd8 - width_ff));
   assign sr16   = {8'h00, sm} << dc8;
   assign s16    = {8'h00, s} << dc8;
   assign merged = ({rdata_eff, left_ff} & ~sr16) | s16;

   // Canvas memory port control.
   assign ram_we    = (cmd.wr_left && left_ok) || (cmd.wr_right && right_ok);
   assign ram_waddr = cmd.wr_right ? addr8 : addr0;
   assign ram_wdata = cmd.wr_right ? right_ff : merged[7:0];
   assign seq_addr  = {seq_dev_ff[DEVICE_W-1:0], seq_row_ff};

   always_comb begin
      unique case (cmd.rd_sel)
         RD_LEFT:  ram_raddr = addr0;
         RD_RIGHT: ram_raddr = addr8;
         RD_SEQ:   ram_raddr = seq_addr;
         default:  ram_raddr = seq_addr;
      endcase
   end

   lmcb_ram #(
      .WIDTH (8),
      .DEPTH (CANVAS_DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // An entry never written since reset or clear reads as zero.
   assign rdata_eff = rd_valid_ff ? ram_rdata : 8'h00;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[ram_raddr];
      end
   end

   // Masks over the devices in use; above_mask holds the devices past the
   // one being scanned, and is empty while device 7 is scanned.
   assign used_mask  = MAX_DEVICES'((16'h0001 << count_ff) - 16'h0001);
   assign above_mask = MAX_DEVICES'({MAX_DEVICES{1'b1}}
                                    << ({1'b0, seq_dev_ff[DEVICE_W-1:0]} + 4'd1));
   assign remaining  = dirty_ff & used_mask & above_mask;

   always_comb begin
      for (int d = 0; d < MAX_DEVICES; d++) begin
         clear_bits[d*ROWS_PER_DEVICE +: ROWS_PER_DEVICE] = {ROWS_PER_DEVICE{used_mask[d]}};
      end
   end

   // Valid bits, dirty mask, counters and the device count register.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_canvas) begin
         valid_in = valid_ff & ~clear_bits;
      end
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end

      dirty_in = dirty_ff;
      if (cmd.clear_dirty) begin
         dirty_in = '0;
      end else if (cmd.clear_canvas) begin
         dirty_in = dirty_ff | used_mask;
      end else if (cmd.wr_left) begin
         dirty_in = dirty_ff | dirty_add;
      end

      seq_dev_in = seq_dev_ff;
      seq_row_in = seq_row_ff;
      if (cmd.seq_start) begin
         seq_dev_in = '0;
         seq_row_in = '0;
      end else if (cmd.next_dev) begin
         seq_dev_in = seq_dev_ff + 1'b1;
         seq_row_in = '0;
      end else if (cmd.next_row) begin
         seq_row_in = seq_row_ff + 1'b1;
      end

      count_in = count_ff;
      if (csr_write_enable) begin
         if ((csr_write_data == '0) || (csr_write_data > DEVICE_COUNT_RESET)) begin
            count_in = DEVICE_COUNT_RESET;
         end else begin
            count_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         dirty_ff   <= '0;
         seq_dev_ff <= '0;
         seq_row_ff <= '0;
         count_ff   <= DEVICE_COUNT_RESET;
      end else begin
         valid_ff   <= valid_in;
         dirty_ff   <= dirty_in;
         seq_dev_ff <= seq_dev_in;
         seq_row_ff <= seq_row_in;
         count_ff   <= count_in;
      end
   end

   // Blit holding registers.
   always_ff @(posedge clock) begin
      if (cmd.cap_left) begin
         left_ff <= rdata_eff;
      end
      if (cmd.wr_left) begin
         right_ff <= merged[15:8];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_seq_rsp) begin
         rsp_device_ff <= seq_dev_ff[DEVICE_W-1:0];
         rsp_reg_ff    <= {1'b0, seq_row_ff} + 4'd1;
         rsp_data_ff   <= rdata_eff;
         rsp_last_ff   <= (seq_row_ff == ROW_W'(ROWS_PER_DEVICE - 1)) && (remaining == '0);
      end else if (cmd.load_bcast_rsp) begin
         rsp_device_ff <= seq_dev_ff[DEVICE_W-1:0];
         if (cmd_ff == CMD_SET_INTENSITY) begin
            rsp_reg_ff  <= REG_INTENSITY;
            rsp_data_ff <= value_ff;
         end else begin
            rsp_reg_ff  <= REG_SHUTDOWN;
            rsp_data_ff <= {7'b0000000, value_ff == 8'h00};
         end
         rsp_last_ff <= (seq_dev_ff + 1'b1) == count_ff;
      end
   end

   assign rsp_device           = rsp_device_ff;
   assign rsp_register_address = rsp_reg_ff;
   assign rsp_write_data       = rsp_data_ff;
   assign rsp_last             = rsp_last_ff;

   // Status toward the controller.
   assign status.command      = cmd_ff;
   assign status.blit_ok      = width_ok && on_screen;
   assign status.intensity_ok = (value_ff[7:4] == 4'h0);
   assign status.scan_done    = (seq_dev_ff >= count_ff);
   assign status.scan_hit     = dirty_ff[seq_dev_ff[DEVICE_W-1:0]];
   assign status.row_last     = (seq_row_ff == ROW_W'(ROWS_PER_DEVICE - 1));
   assign status.bcast_last   = (seq_dev_ff + 1'b1) == count_ff;

endmodule

@@ hdl/led_matrix_canvas_blit_refresh.sv @@
// Blit: after acceptance the controller steps through decode, two canvas reads
// and two canvas writes (one RAM read port, one write port) before the next transaction can be taken.
// Refresh and clear: decode, then a scan over the devices in use; each register
// write takes a RAM read, a result load and a result handoff, which may stall.
// Intensity and shutdown: a result load and handoff per device in use.
// Synchronous active-high reset; the canvas reads as zero right after reset.
// -----------------------------------------------------------------------------
// led_matrix_canvas_blit_refresh
// Canvas blitter and refresh sequencer for a chain of 8x8 LED matrix driver
// devices, built as a controller and a datapath.
// -----------------------------------------------------------------------------
module led_matrix_canvas_blit_refresh
   import lmcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_command,
   input  logic signed [6:0]   req_display_column,
   input  logic [3:0]          req_sprite_width,
   input  logic [2:0]          req_row,
   input  logic [7:0]          req_sprite_byte,
   input  logic [7:0]          req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DEVICE_W-1:0] rsp_device,
   output logic [3:0]          rsp_register_address,
   output logic [7:0]          rsp_write_data,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencing of each transaction.
   lmcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Canvas storage and result formation.
   lmcb_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_display_column   (req_display_column),
      .req_sprite_width     (req_sprite_width),
      .req_row              (req_row),
      .req_sprite_byte      (req_sprite_byte),
      .req_value            (req_value),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd                  (dp_cmd),
      .status               (dp_status),
      .rsp_device           (rsp_device),
      .rsp_register_address (rsp_register_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_last             (rsp_last)
   );

endmodule

@@ hdl/lmcb_checker.sv @@
// -----------------------------------------------------------------------------
// lmcb_checker
// Port-level assertions for the canvas blitter, attached to the top level.
// -----------------------------------------------------------------------------
module lmcb_checker
   import lmcb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DEVICE_W-1:0] rsp_device,
   input logic [3:0]          rsp_register_address,
   input logic [7:0]          rsp_write_data,
   input logic                rsp_last
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_device)
         && $stable(rsp_register_address) && $stable(rsp_write_data) && $stable(rsp_last))
      else $error("stalled result changed");

   // One transaction at a time: no new request is taken while a result is offered.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // Accepting a transaction closes the request side for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after acceptance");

   // Only row, intensity and shutdown registers are written.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_register_address != 4'd0 && rsp_register_address <= 4'd8)
         || rsp_register_address == REG_INTENSITY || rsp_register_address == REG_SHUTDOWN)
      else $error("bad register address");

   // Shutdown writes carry only a zero or a one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_register_address == REG_SHUTDOWN |-> rsp_write_data <= 8'd1)
      else $error("bad shutdown data");

endmodule

bind led_matrix_canvas_blit_refresh lmcb_checker u_checker (.*);

@@ verif/lmcb_register_write_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix canvas register write checker
// Watches the command and register write channels of the canvas blitter. It
// keeps its own canvas, dirty mask and device count, predicts the register
// writes of every accepted command, and compares each accepted write, field by
// field, with the oldest prediction.
// -----------------------------------------------------------------------------
module lmcb_register_write_checker
   import lmcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [2:0]          req_command,
   input  logic signed [6:0]   req_display_column,
   input  logic [3:0]          req_sprite_width,
   input  logic [2:0]          req_row,
   input  logic [7:0]          req_sprite_byte,
   input  logic [7:0]          req_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [DEVICE_W-1:0] rsp_device,
   input  logic [3:0]          rsp_register_address,
   input  logic [7:0]          rsp_write_data,
   input  logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   output int                  failures,
   output int                  outstanding
);

   // One register write to one device of the chain.
   typedef struct packed {
      logic [DEVICE_W-1:0] device;
      logic [3:0]          register_address;
      logic [7:0]          write_data;
      logic                last;
   } panel_write_t;

   logic [7:0]   canvas [CANVAS_DEPTH];
   logic [7:0]   dirty_devices;
   int           active_devices;
   panel_write_t expected_writes [$];
   panel_write_t command_writes [$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   // Mirror image of a byte, bit 0 swapped with bit 7 and so on.
   function automatic logic [7:0] flip_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

   function automatic void add_write(input int dev, input logic [3:0] addr,
                                     input logic [7:0] data);
      panel_write_t w;
      w.device           = DEVICE_W'(dev);
      w.register_address = addr;
      w.write_data       = data;
      w.last             = 1'b0;
      command_writes.push_back(w);
   endfunction

   // Merges the top bits of the mirrored sprite byte into the canvas row pair
   // around the display column and marks the touched devices dirty.
   function automatic void merge_sprite_row(input int col, input int width, input int row,
                                            input logic [7:0] sprite);
      int          dc8;
      int          base;
      int          dev;
      int          left_at;
      int          right_at;
      logic [7:0]  touched;
      logic [15:0] pair_bytes;
      logic [15:0] field_mask;
      logic [15:0] bits;
      if (width == 0 || width > ROWS_PER_DEVICE) return;
      if (col + width < 1 || col >= active_devices * ROWS_PER_DEVICE) return;
      dc8  = col & 7;
      base = col - dc8;
      dev  = col / 8;
      // A sprite that runs past the byte boundary also dirties the next device;
      // anything shifted beyond the last device is dropped.
      touched = (dc8 + width <= 8) ? 8'h01 : 8'h03;
      dirty_devices = dirty_devices | (touched << dev);
      left_at    = base + row;
      right_at   = left_at + 8;
      pair_bytes = {canvas[right_at & 63], canvas[(left_at + 64) & 63]};
      field_mask = (16'd1 << width) - 16'd1;
      bits       = field_mask & (16'(flip_byte(sprite)) >> (8 - width));
      pair_bytes = (pair_bytes & ~(field_mask << dc8)) | (bits << dc8);
      // Reads wrap around the canvas, writes outside it are dropped.
      if (left_at >= 0) canvas[left_at & 63] = pair_bytes[7:0];
      if (right_at < CANVAS_DEPTH) canvas[right_at & 63] = pair_bytes[15:8];
   endfunction

   // Row writes of every dirty device in use, then a clean mask.
   function automatic void queue_dirty_rows();
      for (int d = 0; d < active_devices; d++) begin
         if (dirty_devices[d]) begin
            for (int r = 0; r < ROWS_PER_DEVICE; r++) begin
               add_write(d, 4'(r + 1), canvas[d * ROWS_PER_DEVICE + r]);
            end
         end
      end
      dirty_devices = '0;
   endfunction

   always @(posedge clock) begin
      panel_write_t got;
      panel_write_t want;
      if (reset) begin
         foreach (canvas[i]) canvas[i] = '0;
         dirty_devices  = '0;
         active_devices = MAX_DEVICES;
         expected_writes.delete();
      end else begin
         // Device count register; out of range values select the full chain.
         if (csr_write_enable) begin
            active_devices = (csr_write_data == 0 || csr_write_data > MAX_DEVICES) ?
                             MAX_DEVICES : int'(csr_write_data);
         end

         // Predict the writes of an accepted command transaction.
         if (req_valid && req_ready) begin
            command_writes.delete();
            case (req_command)
               CMD_BLIT_ROW: begin
                  merge_sprite_row(int'(req_display_column), int'(req_sprite_width),
                                   int'(req_row), req_sprite_byte);
               end
               CMD_REFRESH: begin
                  queue_dirty_rows();
               end
               CMD_CLEAR: begin
                  for (int d = 0; d < active_devices; d++) begin
                     for (int r = 0; r < ROWS_PER_DEVICE; r++) begin
                        canvas[d * ROWS_PER_DEVICE + r] = '0;
                     end
                     dirty_devices[d] = 1'b1;
                  end
                  queue_dirty_rows();
               end
               CMD_SET_INTENSITY: begin
                  if (req_value < 16) begin
                     for (int d = 0; d < active_devices; d++) begin
                        add_write(d, REG_INTENSITY, req_value);
                     end
                  end
               end
               CMD_SET_SHUTDOWN: begin
                  for (int d = 0; d < active_devices; d++) begin
                     add_write(d, REG_SHUTDOWN, (req_value != 0) ? 8'd0 : 8'd1);
                  end
               end
               default: begin
               end
            endcase
            foreach (command_writes[i]) begin
               want      = command_writes[i];
               want.last = (i == command_writes.size() - 1);
               expected_writes.push_back(want);
            end
         end

         // Compare an accepted register write transaction with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            got.device           = rsp_device;
            got.register_address = rsp_register_address;
            got.write_data       = rsp_write_data;
            got.last             = rsp_last;
            if (expected_writes.size() == 0) begin
               $error("unexpected register write: device %0d register %0d data 0x%02h",
                      got.device, got.register_address, got.write_data);
               failures++;
            end else begin
               want = expected_writes.pop_front();
               if (got.device !== want.device) begin
                  $error("device: expected %0d, actual %0d", want.device, got.device);
                  failures++;
               end
               if (got.register_address !== want.register_address) begin
                  $error("register_address: expected %0d, actual %0d",
                         want.register_address, got.register_address);
                  failures++;
               end
               if (got.write_data !== want.write_data) begin
                  $error("write_data: expected 0x%02h, actual 0x%02h",
                         want.write_data, got.write_data);
                  failures++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, got.last);
                  failures++;
               end
            end
         end
      end
      outstanding <= expected_writes.size();
   end

endmodule

@@ verif/led_matrix_canvas_blit_refresh_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// LED matrix canvas blitter testbench
// Drives directed and random commands into the canvas blitter under several
// device counts, with random gaps and stalls on both channels, a long receiver
// hold-off and drains between phases. A checker beside the block predicts and
// compares every register write; this module only makes stimulus and decides.
// -----------------------------------------------------------------------------
module led_matrix_canvas_blit_refresh_tb;
   import lmcb_pkg::*;

   localparam int          SETTLE_CYCLES  = 20;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          PHASE_ITEMS    = 25;
   localparam logic [2:0]  CMD_UNKNOWN_LO = 3'd5;
   localparam logic [2:0]  CMD_UNKNOWN_MID = 3'd6;
   localparam logic [2:0]  CMD_UNKNOWN_HI = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [2:0]          req_command = '0;
   logic signed [6:0]   req_display_column = '0;
   logic [3:0]          req_sprite_width = '0;
   logic [2:0]          req_row = '0;
   logic [7:0]          req_sprite_byte = '0;
   logic [7:0]          req_value = '0;
   logic                rsp_ready = 1'b0;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data = '0;
   logic                req_ready;
   logic                rsp_valid;
   logic [DEVICE_W-1:0] rsp_device;
   logic [3:0]          rsp_register_address;
   logic [7:0]          rsp_write_data;
   logic                rsp_last;
   int                  failures;
   int                  outstanding;
   bit                  idling_on = 1'b1;
   bit                  hold_request = 1'b0;

   always #5 clock = ~clock;

   led_matrix_canvas_blit_refresh dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_display_column   (req_display_column),
      .req_sprite_width     (req_sprite_width),
      .req_row              (req_row),
      .req_sprite_byte      (req_sprite_byte),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_device           (rsp_device),
      .rsp_register_address (rsp_register_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_last             (rsp_last),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   lmcb_register_write_checker u_write_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_display_column   (req_display_column),
      .req_sprite_width     (req_sprite_width),
      .req_row              (req_row),
      .req_sprite_byte      (req_sprite_byte),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_device           (rsp_device),
      .rsp_register_address (rsp_register_address),
      .rsp_write_data       (rsp_write_data),
      .rsp_last             (rsp_last),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .failures             (failures),
      .outstanding          (outstanding)
   );

   // Offers one command transaction, after an optional random gap, and returns
   // at the edge where it is accepted.
   task automatic send_command(input logic [2:0] cmd, input logic [6:0] col,
                               input logic [3:0] width, input logic [2:0] row,
                               input logic [7:0] sprite, input logic [7:0] value);
      if (idling_on) begin
         while ($urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_display_column <= col;
      req_sprite_width   <= width;
      req_row            <= row;
      req_sprite_byte    <= sprite;
      req_value          <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering, waits for every predicted write, then lets a blit or a
   // silent command still in flight finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_device_count(input logic [COUNT_W-1:0] count);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random command, mostly blits near the visible columns with legal widths.
   // Reports whether the block has anything to do with it.
   task automatic send_random_command(output bit counted);
      int         pick;
      int         column;
      logic [2:0] cmd;
      logic [6:0] col;
      logic [3:0] width;
      logic [7:0] value;
      pick = $urandom_range(99);
      if (pick < 58) cmd = CMD_BLIT_ROW;
      else if (pick < 72) cmd = CMD_REFRESH;
      else if (pick < 77) cmd = CMD_CLEAR;
      else if (pick < 86) cmd = CMD_SET_INTENSITY;
      else if (pick < 95) cmd = CMD_SET_SHUTDOWN;
      else cmd = 3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
      if ($urandom_range(9) == 0) begin
         col = 7'($urandom);
      end else begin
         column = int'($urandom_range(71)) - 8;
         col    = column[6:0];
      end
      width = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
      if (cmd == CMD_SET_INTENSITY && $urandom_range(4) != 0) value = 8'($urandom_range(15));
      else if (cmd == CMD_SET_SHUTDOWN && $urandom_range(1) == 0) value = 8'd0;
      else value = 8'($urandom);
      send_command(cmd, col, width, 3'($urandom), 8'($urandom), value);
      counted = !(cmd > CMD_SET_SHUTDOWN ||
                  (cmd == CMD_BLIT_ROW && (width == 0 || width > 8)));
   endtask

   // Receiver: random stalls, or a long hold-off when asked for one.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= idling_on ? ($urandom_range(99) >= 34) : 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] phase_counts [6];
      int                 done_items;
      bit                 counted;
      phase_counts = '{4'd1, 4'd8, 4'd0, 4'd5, 4'd15, 4'd2};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_device_count(4'd8);

      // Directed: empty refresh, bad widths, screen edges, straddles, every
      // broadcast case and the unknown command codes.
      send_command(CMD_REFRESH, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd0, 4'd0, 3'd1, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd0, 4'd9, 3'd1, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd8, 4'd15, 3'd2, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'(-8), 4'd8, 3'd0, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'(-7), 4'd8, 3'd0, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd63, 4'd8, 3'd7, 8'h5a, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd0, 4'd8, 3'd7, 8'h81, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd13, 4'd5, 3'd3, 8'ha5, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd20, 4'd1, 3'd2, 8'h80, 8'hff);
      send_command(CMD_BLIT_ROW, 7'd40, 4'd8, 3'd4, 8'h00, 8'h00);
      send_command(CMD_REFRESH, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
      send_command(CMD_SET_INTENSITY, 7'd0, 4'd0, 3'd0, 8'h00, 8'd0);
      send_command(CMD_SET_INTENSITY, 7'd0, 4'd0, 3'd0, 8'h00, 8'd15);
      send_command(CMD_SET_INTENSITY, 7'd0, 4'd0, 3'd0, 8'h00, 8'd16);
      send_command(CMD_SET_INTENSITY, 7'd0, 4'd0, 3'd0, 8'h00, 8'd255);
      send_command(CMD_SET_SHUTDOWN, 7'd0, 4'd0, 3'd0, 8'h00, 8'd0);
      send_command(CMD_SET_SHUTDOWN, 7'd0, 4'd0, 3'd0, 8'h00, 8'd1);
      send_command(CMD_SET_SHUTDOWN, 7'd0, 4'd0, 3'd0, 8'h00, 8'd255);
      send_command(CMD_CLEAR, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
      send_command(CMD_REFRESH, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
      send_command(CMD_UNKNOWN_LO, 7'd5, 4'd3, 3'd1, 8'hff, 8'hff);
      send_command(CMD_UNKNOWN_MID, 7'd5, 4'd3, 3'd1, 8'hff, 8'hff);
      send_command(CMD_UNKNOWN_HI, 7'd5, 4'd3, 3'd1, 8'hff, 8'hff);
      wait_idle();

      // Short chain: a blit past the last device and one whose right half
      // lands on an unused device.
      write_device_count(4'd3);
      send_command(CMD_BLIT_ROW, 7'd24, 4'd4, 3'd0, 8'hff, 8'h00);
      send_command(CMD_BLIT_ROW, 7'd23, 4'd2, 3'd5, 8'hc0, 8'h00);
      send_command(CMD_BLIT_ROW, 7'(-3), 4'd4, 3'd1, 8'hff, 8'h00);
      send_command(CMD_REFRESH, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
      wait_idle();

      // Random phases, each under its own device count.
      foreach (phase_counts[p]) begin
         write_device_count(phase_counts[p]);
         idling_on = (p != 2);
         if (p == 1) begin
            // Long receiver hold-off while a full clear and more commands queue up.
            hold_request = 1'b1;
            send_command(CMD_CLEAR, 7'd0, 4'd0, 3'd0, 8'h00, 8'h00);
         end
         done_items = 0;
         while (done_items < PHASE_ITEMS) begin
            send_random_command(counted);
            if (counted) done_items++;
         end
         wait_idle();
      end
      idling_on = 1'b1;

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
